// ===== rtl/core/ocu_pkg.sv =====
// ----------------------------------------------------------------------------
// ocu_pkg
// Shared types and constants of the occupancy cell hit/visit update unit.
// ----------------------------------------------------------------------------
package ocu_pkg;

	localparam int CNT_W = 16;
	localparam int HGT_W = 16;

	localparam logic [CNT_W-1:0] COUNT_MAX    = 16'hFFFF;
	localparam logic [HGT_W-1:0] HEIGHT_RESET = 16'h7FFF;
	localparam logic [CNT_W-1:0] THRESH_RESET = 16'd3;

	localparam logic OP_UPDATE = 1'b0;
	localparam logic OP_QUERY  = 1'b1;

	typedef struct packed {
		logic        [CNT_W-1:0] hits;
		logic        [CNT_W-1:0] visits;
		logic signed [HGT_W-1:0] height;
	} cell_t;

	typedef struct packed {
		logic active;
		logic wr_en;
	} clr_status_t;

endpackage

// ===== rtl/core/ocu_cell_ram.sv =====
// ----------------------------------------------------------------------------
// ocu_cell_ram
// Cell store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ocu_cell_ram
	import ocu_pkg::*;
#(
	parameter int DEPTH  = 4096,
	parameter int ADDR_W = 12
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  cell_t             wr_data,
	input  logic [ADDR_W-1:0] rd_addr,
	output cell_t             rd_data
);

	cell_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule

// ===== rtl/core/ocu_clear_seq.sv =====
// ----------------------------------------------------------------------------
// ocu_clear_seq
// Clearing pass after reset: walks every cell address once.
// ----------------------------------------------------------------------------
module ocu_clear_seq
	import ocu_pkg::*;
#(
	parameter int DEPTH  = 4096,
	parameter int ADDR_W = 12
) (
	input  logic              clk,
	input  logic              arst_n,
	output clr_status_t       status,
	output logic [ADDR_W-1:0] addr
);

	logic [ADDR_W-1:0] addr_q;
	logic              active_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q   <= '0;
			active_q <= 1'b1;
		end else if (active_q) begin
			if (addr_q == ADDR_W'(DEPTH - 1)) begin
				active_q <= 1'b0;
			end
			addr_q <= addr_q + 1'b1;
		end
	end

	assign status.active = active_q;
	assign status.wr_en  = active_q;
	assign addr          = addr_q;

endmodule

// ===== rtl/core/ocu_cell_alu.sv =====
// ----------------------------------------------------------------------------
// ocu_cell_alu
// Next-state logic of one cell for an update or query request.
// ----------------------------------------------------------------------------
module ocu_cell_alu
	import ocu_pkg::*;
(
	input  cell_t                   cur,
	input  logic                    opcode,
	input  logic                    hit,
	input  logic signed [HGT_W-1:0] point_height,
	input  logic        [CNT_W-1:0] threshold,
	output cell_t                   nxt
);

	logic              lower;
	logic [CNT_W-1:0]  hits_inc;
	logic [CNT_W-1:0]  visits_inc;

	assign lower      = point_height < cur.height;
	assign hits_inc   = (cur.hits == COUNT_MAX) ? COUNT_MAX : cur.hits + 1'b1;
	assign visits_inc = (cur.visits == COUNT_MAX) ? COUNT_MAX : cur.visits + 1'b1;

	always_comb begin
		nxt = cur;
		if (opcode == OP_UPDATE) begin
			if (hit) begin
				if (lower) begin
					nxt.height = point_height;
					nxt.hits   = hits_inc;
					nxt.visits = visits_inc;
				end
			end else if (cur.hits > threshold) begin
				if (lower) begin
					nxt.visits = visits_inc;
				end
			end else begin
				nxt.visits = visits_inc;
				nxt.height = point_height;
			end
		end
	end

endmodule

// ===== rtl/core/occupancy_cell_hit_visit_update_unit.sv =====
// ----------------------------------------------------------------------------
// occupancy_cell_hit_visit_update_unit
// Occupancy subgrid cell store with hit/visit counting and a per-cell height.
// ----------------------------------------------------------------------------
// After reset the unit runs a clearing pass over all GRID_WIDTH*GRID_ROWS
// cells with busy high; configuration writes are taken during it. Then it
// accepts one request per cycle. The result of a request is shown with done
// for one cycle: the accepting edge also takes the cell store's registered
// read, the next edge does the read-modify-write, loads the result register
// and raises done.
// A request to the cell written by the request just before it takes the
// written value from a forwarding register. Results cannot be held off.
module occupancy_cell_hit_visit_update_unit
	import ocu_pkg::*;
#(
	parameter int GRID_WIDTH = 64,
	parameter int GRID_ROWS  = 64
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic                    opcode,
	input  logic                    hit,
	input  logic [5:0]              cell_x,
	input  logic [5:0]              cell_y,
	input  logic signed [HGT_W-1:0] point_height,
	output logic                    done,
	output logic [CNT_W-1:0]        hit_total,
	output logic [CNT_W-1:0]        visit_total,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [CNT_W-1:0]        cfg_data
);

	localparam int DEPTH  = GRID_WIDTH * GRID_ROWS;
	localparam int ADDR_W = $clog2(DEPTH);

	logic [CNT_W-1:0]  thresh_q;
	clr_status_t       clr_status;
	logic [ADDR_W-1:0] clr_addr;

	logic              accept;
	logic [31:0]       idx_full;
	logic              in_range;
	logic [ADDR_W-1:0] rd_addr;
	cell_t             rd_data;

	logic                    valid_s1;
	logic                    in_range_s1;
	logic [ADDR_W-1:0]       addr_s1;
	logic                    opcode_s1;
	logic                    hit_s1;
	logic signed [HGT_W-1:0] height_s1;

	logic              wb_valid_q;
	logic [ADDR_W-1:0] wb_addr_q;
	cell_t             wb_data_q;

	cell_t             cur_cell;
	cell_t             nxt_cell;
	logic              wr_en;
	logic [ADDR_W-1:0] wr_addr;
	cell_t             wr_data;
	cell_t             clr_cell;

	logic              done_q;
	logic [CNT_W-1:0]  hit_total_q;
	logic [CNT_W-1:0]  visit_total_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q <= THRESH_RESET;
		end else if (cfg_valid && cfg_ready) begin
			thresh_q <= cfg_data;
		end
	end

	ocu_clear_seq #(
		.DEPTH  (DEPTH),
		.ADDR_W (ADDR_W)
	) u_clear (
		.clk    (clk),
		.arst_n (arst_n),
		.status (clr_status),
		.addr   (clr_addr)
	);

	assign busy     = clr_status.active;
	assign accept   = start && !busy;
	assign idx_full = 32'(cell_x) + 32'(cell_y) * 32'(GRID_WIDTH);
	assign in_range = (32'(cell_x) < 32'(GRID_WIDTH)) && (32'(cell_y) < 32'(GRID_ROWS));
	assign rd_addr  = idx_full[ADDR_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			in_range_s1 <= in_range;
			addr_s1     <= rd_addr;
			opcode_s1   <= opcode;
			hit_s1      <= hit;
			height_s1   <= point_height;
		end
	end

	// forward the entry written at the edge the read was taken
	assign cur_cell = (wb_valid_q && wb_addr_q == addr_s1) ? wb_data_q : rd_data;

	ocu_cell_alu u_alu (
		.cur          (cur_cell),
		.opcode       (opcode_s1),
		.hit          (hit_s1),
		.point_height (height_s1),
		.threshold    (thresh_q),
		.nxt          (nxt_cell)
	);

	assign clr_cell.hits   = '0;
	assign clr_cell.visits = '0;
	assign clr_cell.height = HEIGHT_RESET;

	always_comb begin
		if (clr_status.wr_en) begin
			wr_en   = 1'b1;
			wr_addr = clr_addr;
			wr_data = clr_cell;
		end else begin
			wr_en   = valid_s1 && in_range_s1;
			wr_addr = addr_s1;
			wr_data = nxt_cell;
		end
	end

	ocu_cell_ram #(
		.DEPTH  (DEPTH),
		.ADDR_W (ADDR_W)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wb_valid_q <= 1'b0;
		end else begin
			wb_valid_q <= valid_s1 && in_range_s1;
		end
	end

	always_ff @(posedge clk) begin
		wb_addr_q <= addr_s1;
		wb_data_q <= nxt_cell;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			hit_total_q   <= in_range_s1 ? nxt_cell.hits : '0;
			visit_total_q <= in_range_s1 ? nxt_cell.visits : '0;
		end
	end

	assign done        = done_q;
	assign hit_total   = hit_total_q;
	assign visit_total = visit_total_q;

	a_no_request_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clr_status.active |-> !valid_s1)
		else $error("request in flight during clearing pass");

	a_visits_cover_hits: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> visit_total >= hit_total)
		else $error("visit count below hit count");

	a_done_follows_request: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> ##1 done)
		else $error("result missing for accepted request");

	a_out_of_range_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !in_range_s1) |=> (hit_total == '0 && visit_total == '0))
		else $error("out-of-range request returned nonzero counts");

endmodule
